### hw/rtl/dpd_pkg.sv
// Shared types, constants and helpers for the debug packet deframer.
package dpd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int LEN_WIDTH   = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [CFG_WIDTH-1:0] MAX_PAYLOAD_RESET = CFG_WIDTH'(400);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NAK   = 8'h2D;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABANDON = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [7:0]           data;
    logic [LEN_WIDTH-1:0] len;
  } result_t;

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h41:8'h46]}) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 4'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 4'(c - 8'h30);
    end
    return v;
  endfunction

endpackage

### hw/rtl/debug_packet_deframer.sv
// Debug packet deframer: '$' payload '#' hh framing with checksum check.
// The result for an accepted byte is registered and shown on the master side in the next cycle.
// Throughput: one byte per cycle; the single result register drains while the next
// byte is taken, so the input stalls only while the consumer holds tready low.
// Reset: hunting for '$', sum and count zero, max_payload 400, no result held.
module debug_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] data, [23:8] payload_length
  output logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // max_payload
);

  logic [dpd_pkg::CFG_WIDTH-1:0] max_payload;
  logic                          take_ready;
  logic                          step;
  dpd_pkg::result_t              res;

  assign cfg_ready = 1'b1;
  assign s_tready  = take_ready;
  assign step      = s_tvalid && take_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= dpd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  dpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (s_tdata),
    .max_payload (max_payload),
    .res         (res)
  );

  dpd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .res        (res),
    .take_ready (take_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

### hw/rtl/dpd_core.sv
// Framing state machine: hunts for start, sums payload, abandons over-long packets, checks the checksum.
module dpd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [7:0]                     rx_byte,
  input  logic [dpd_pkg::CFG_WIDTH-1:0]  max_payload,
  output dpd_pkg::result_t               res
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_CS1  = 2'd2,
    PH_CS2  = 2'd3
  } phase_t;

  phase_t                              phase, phase_next;
  logic [7:0]                          running_sum, running_sum_next;
  logic [dpd_pkg::COUNT_WIDTH-1:0]     byte_count, byte_count_next;
  logic [3:0]                          high_nibble, high_nibble_next;
  logic                                full;
  logic [7:0]                          got;

  assign full = (dpd_pkg::CMP_WIDTH'(byte_count) >= dpd_pkg::CMP_WIDTH'(max_payload))
             || (byte_count == {dpd_pkg::COUNT_WIDTH{1'b1}});
  assign got  = {high_nibble, dpd_pkg::hex_value(rx_byte)};

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    byte_count_next  = byte_count;
    high_nibble_next = high_nibble;
    res              = '0;
    res.kind         = dpd_pkg::KIND_PAYLOAD;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == dpd_pkg::CH_START) begin
          phase_next       = PH_DATA;
          running_sum_next = 8'd0;
          byte_count_next  = '0;
        end
      end
      PH_DATA: begin
        if (full) begin
          res.valid  = 1'b1;
          res.kind   = dpd_pkg::KIND_ABANDON;
          res.data   = 8'd0;
          res.len    = dpd_pkg::LEN_WIDTH'(byte_count);
          phase_next = PH_HUNT;
          // a start byte here opens the next packet at once
          if (rx_byte == dpd_pkg::CH_START) begin
            phase_next       = PH_DATA;
            running_sum_next = 8'd0;
            byte_count_next  = '0;
          end
        end else if (rx_byte == dpd_pkg::CH_END) begin
          phase_next = PH_CS1;
        end else if (rx_byte == dpd_pkg::CH_START) begin
          running_sum_next = 8'd0;
          byte_count_next  = '0;
        end else begin
          running_sum_next = running_sum + rx_byte;
          byte_count_next  = byte_count + 1'b1;
          res.valid        = 1'b1;
          res.kind         = dpd_pkg::KIND_PAYLOAD;
          res.data         = rx_byte;
          res.len          = dpd_pkg::LEN_WIDTH'(byte_count_next);
        end
      end
      PH_CS1: begin
        high_nibble_next = dpd_pkg::hex_value(rx_byte);
        phase_next       = PH_CS2;
      end
      PH_CS2: begin
        phase_next = PH_HUNT;
        res.valid  = 1'b1;
        res.len    = dpd_pkg::LEN_WIDTH'(byte_count);
        if (got == running_sum) begin
          res.kind = dpd_pkg::KIND_GOOD;
          res.data = dpd_pkg::CH_ACK;
        end else begin
          res.kind = dpd_pkg::KIND_BAD;
          res.data = dpd_pkg::CH_NAK;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= 8'd0;
      byte_count  <= '0;
      high_nibble <= 4'd0;
    end else if (step) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      byte_count  <= byte_count_next;
      high_nibble <= high_nibble_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_hunts: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && (res.kind == dpd_pkg::KIND_GOOD || res.kind == dpd_pkg::KIND_BAD)
    |=> phase == PH_HUNT)
    else $error("packet end did not return to hunting");

  a_abandon_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.kind == dpd_pkg::KIND_ABANDON
    |=> (phase == PH_HUNT) || (byte_count == '0))
    else $error("abandon left a live packet count");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    step && res.valid && res.kind == dpd_pkg::KIND_PAYLOAD
    |=> byte_count == $past(byte_count) + 1'b1)
    else $error("payload word did not advance the count");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(byte_count) && $stable(running_sum))
    else $error("state moved without an accepted word");
`endif

endmodule

### hw/rtl/dpd_out.sv
// Result register with stream handshake toward the consumer.
module dpd_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  dpd_pkg::result_t  res,
  output logic              take_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic [1:0]        m_tuser
);

  logic                             valid;
  logic [7:0]                       data;
  logic [dpd_pkg::LEN_WIDTH-1:0]    len;
  dpd_pkg::kind_t                   kind;

  // accept a new word whenever the held result leaves this cycle or none is held
  assign take_ready = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_ready) begin
      valid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready && step && res.valid) begin
      data <= res.data;
      len  <= res.len;
      kind <= res.kind;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {len, data};
  assign m_tuser  = kind;

endmodule

### test/tb_debug_packet_deframer.sv
// Self-checking testbench for the debug packet deframer: framing, checksum and payload limits.
module tb_debug_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dpd_pkg::kind_t                kind;
    logic [7:0]                    data;
    logic [dpd_pkg::LEN_WIDTH-1:0] len;
  } frame_event_t;

  typedef enum logic [1:0] {
    HUNT,
    IN_PAYLOAD,
    SUM_HI,
    SUM_LO
  } track_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] data, [23:8] payload_length
  logic [1:0]  m_tuser;           // [1:0] kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  logic [7:0]   rx_bytes_q[$];
  frame_event_t deframer_events[$];

  // Tracker state mirroring the deframer
  track_phase_t                    trk_phase = HUNT;
  logic [7:0]                      trk_sum = 8'h00;
  logic [dpd_pkg::COUNT_WIDTH-1:0] trk_count = '0;
  logic [3:0]                      trk_high = 4'h0;
  logic [dpd_pkg::CFG_WIDTH-1:0]   trk_limit = dpd_pkg::MAX_PAYLOAD_RESET;

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int bytes_in = 0;
  int limit_writes = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  frame_event_t want, seen;

  debug_packet_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'h0;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic void start_packet();
    trk_phase = IN_PAYLOAD;
    trk_sum   = 8'h00;
    trk_count = '0;
  endfunction

  // Advance the tracker by one accepted byte and queue the word it yields.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] got;
    case (trk_phase)
      HUNT: begin
        if (b == dpd_pkg::CH_START) start_packet();
      end
      IN_PAYLOAD: begin
        if (trk_count >= trk_limit || trk_count == '1) begin
          deframer_events.push_back('{dpd_pkg::KIND_ABANDON, 8'h00, trk_count});
          trk_phase = HUNT;
          if (b == dpd_pkg::CH_START) start_packet();
        end else if (b == dpd_pkg::CH_END) begin
          trk_phase = SUM_HI;
        end else if (b == dpd_pkg::CH_START) begin
          start_packet();
        end else begin
          trk_sum   = trk_sum + b;
          trk_count = trk_count + 1'b1;
          deframer_events.push_back('{dpd_pkg::KIND_PAYLOAD, b, trk_count});
        end
      end
      SUM_HI: begin
        trk_high  = hex_digit_value(b);
        trk_phase = SUM_LO;
      end
      default: begin
        got = {trk_high, hex_digit_value(b)};
        trk_phase = HUNT;
        if (got == trk_sum)
          deframer_events.push_back('{dpd_pkg::KIND_GOOD, dpd_pkg::CH_ACK, trk_count});
        else
          deframer_events.push_back('{dpd_pkg::KIND_BAD, dpd_pkg::CH_NAK, trk_count});
      end
    endcase
  endfunction

  // Byte source
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) begin
        deframe_byte(s_tdata);
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99, 0) >= src_gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_bytes_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Result sink
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
      if (m_tvalid && m_tready) begin
        seen = '{dpd_pkg::kind_t'(m_tuser), m_tdata[7:0], m_tdata[23:8]};
        if (deframer_events.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected word, expected none, actual kind %0d data %0h len %0d",
                     $time, seen.kind, seen.data, seen.len);
        end else begin
          want = deframer_events.pop_front();
          check_field("kind", 16'(want.kind), 16'(seen.kind));
          check_field("data", 16'(want.data), 16'(seen.data));
          check_field("payload_length", want.len, seen.len);
          kind_seen[want.kind]++;
        end
      end
    end
  end

  task automatic push_text(input string s);
    foreach (s[i]) rx_bytes_q.push_back(s[i]);
  endtask

  // Queue one packet, mostly well formed, with noise and breaks mixed in.
  task automatic add_packet(input int limit, inout int made);
    int n;
    int r;
    logic [7:0] b;
    logic [7:0] sum;
    bit lower;
    if ($urandom_range(4, 0) == 0)
      repeat ($urandom_range(3, 1)) rx_bytes_q.push_back(8'($urandom_range(255, 0)));
    if (limit <= 20) n = $urandom_range(limit + 2, 0);
    else if (limit > 1000 || $urandom_range(9, 0) < 8) n = $urandom_range(16, 0);
    else n = $urandom_range(limit + 1, limit - 2);
    rx_bytes_q.push_back(dpd_pkg::CH_START);
    sum = 8'h00;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(59, 0);
      if (r == 0) b = dpd_pkg::CH_START;
      else if (r == 1) b = dpd_pkg::CH_END;
      else b = 8'($urandom_range(255, 0));
      rx_bytes_q.push_back(b);
      sum = sum + b;
    end
    // land a restart right on the full point now and then
    if (n >= limit && limit <= 20 && $urandom_range(3, 0) == 0)
      rx_bytes_q.push_back(dpd_pkg::CH_START);
    rx_bytes_q.push_back(dpd_pkg::CH_END);
    lower = 1'($urandom_range(1, 0));
    if ($urandom_range(3, 0) != 0) begin
      rx_bytes_q.push_back(nibble_char(sum[7:4], lower));
      rx_bytes_q.push_back(nibble_char(sum[3:0], lower));
    end else begin
      rx_bytes_q.push_back(8'($urandom_range(255, 0)));
      rx_bytes_q.push_back(8'($urandom_range(255, 0)));
    end
    made += n + 3;
  endtask

  task automatic add_random(input int limit, input int target);
    int made;
    made = 0;
    while (made < target) add_packet(limit, made);
  endtask

  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || s_tvalid || deframer_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trk_limit = v;
    limit_writes++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct = 31;
    sink_stall_pct = 81;
    // noise while hunting, good, lowercase sum, bad with non-hex digit,
    // restart inside payload, '$' and '#' as checksum digits
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    push_text("$A#41");
    rx_bytes_q.push_back(dpd_pkg::CH_START);
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    push_text("#ff");
    push_text("$ab#0g");
    push_text("$z$#$#");
    wait_drained();
    add_random(400, 350);
    wait_drained();
    write_limit(16'd5);
    add_random(5, 250);
    wait_drained();

    src_gap_pct = 81;
    sink_stall_pct = 31;
    write_limit(16'd0);
    add_random(0, 100);
    wait_drained();
    write_limit(16'd1);
    add_random(1, 150);
    wait_drained();
    write_limit(16'd12);
    add_random(12, 300);
    wait_drained();

    src_gap_pct = 0;
    sink_stall_pct = 0;
    write_limit(16'hFFFF);
    add_random(65535, 150);
    wait_drained();
    write_limit(16'd400);
    add_random(400, 550);
    wait_drained();

    $display("Fed %0d bytes; checked %0d payload words, %0d good, %0d bad, %0d abandoned.",
             bytes_in, kind_seen[dpd_pkg::KIND_PAYLOAD], kind_seen[dpd_pkg::KIND_GOOD],
             kind_seen[dpd_pkg::KIND_BAD], kind_seen[dpd_pkg::KIND_ABANDON]);
    $display("Limit written %0d times (0, 1, 5, 12, 400, 65535); %0d mismatches.",
             limit_writes, errors);
    if (errors == 0) begin
      $display("** debug_packet_deframer: PASSED **");
    end else begin
      $display("** debug_packet_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d words still outstanding", deframer_events.size());
    $display("** debug_packet_deframer: FAILED **");
    $finish;
  end

endmodule
